/* rtl/assert_macros.svh */
// assertion macros used by the queue module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/depq_pkg.sv */
// ---------------------------------------------------------------------------
// depq package
// operation codes and key type shared by the queue modules
// ---------------------------------------------------------------------------
package depq_pkg;
  localparam logic [1:0] FUNC_INSERT  = 2'd0;
  localparam logic [1:0] FUNC_REM_MAX = 2'd1;
  localparam logic [1:0] FUNC_REM_MIN = 2'd2;
  localparam int KEY_W = 32;
  typedef logic signed [KEY_W-1:0] key_t;
endpackage

/* rtl/depq_cmp.sv */
// ---------------------------------------------------------------------------
// depq compare unit
// single signed comparator used by the insertion shift walk
// ---------------------------------------------------------------------------
module depq_cmp (
  input  depq_pkg::key_t a,
  input  depq_pkg::key_t b,
  output logic           gt
);
  assign gt = a > b;
endmodule

/* rtl/double_ended_priority_queue.sv */
// ---------------------------------------------------------------------------
// double ended priority queue
// sorted key store in a ring buffer, one compare unit walks inserts
// ---------------------------------------------------------------------------
// channel | ports                               | handshake
// input   | in_func, in_key                     | start & !busy
// result  | out_max_key, out_min_key, out_is_   | out_valid, one cycle
//         | empty, out_dropped                  |
// removals and refused inserts pass S_RPT0, S_RPT1 and S_RPT2, then raise out_valid
// an insert walks the stored keys from the top, each in S_RD and S_CMP
// (read, compare and shift), then S_PUT writes the key; busy is high meanwhile
// busy drops in the out_valid cycle, so the next item can be taken then
// reset clears the count, head and state; the key memory needs no clearing
`include "assert_macros.svh"
module double_ended_priority_queue #(
  parameter int CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic signed [31:0] in_key,
  output logic        out_valid,
  output logic signed [31:0] out_max_key,
  output logic signed [31:0] out_min_key,
  output logic        out_is_empty,
  output logic        out_dropped
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CMP, S_PUT, S_RPT0, S_RPT1, S_RPT2
  } state_t;

  state_t state_r;
  logic [AW-1:0] head_r;
  logic [CW-1:0] cnt_r, pos_r;
  depq_pkg::key_t key_r, rdat_r;
  logic drop_r;

  depq_pkg::key_t mem [CAPACITY];
  logic          we;
  logic [AW-1:0] waddr, raddr;
  depq_pkg::key_t wdat;
  logic gt;

  // physical address of logical index
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = {1'b0, CW'(h)} + {1'b0, i};
    if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
    return s[AW-1:0];
  endfunction

  depq_cmp u_cmp (.a(rdat_r), .b(key_r), .gt(gt));

  always_comb begin
    we = 1'b0;
    waddr = phys(head_r, pos_r);
    wdat = rdat_r;
    raddr = phys(head_r, pos_r - CW'(1));
    unique case (state_r)
      S_CMP: we = gt;
      S_PUT: begin
        we = 1'b1;
        wdat = key_r;
      end
      S_RPT0: raddr = head_r;
      S_RPT1: raddr = phys(head_r, cnt_r - CW'(1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdat;
    rdat_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      head_r <= '0;
      pos_r <= '0;
      drop_r <= 1'b0;
      out_valid <= 1'b0;
      out_max_key <= '0;
      out_min_key <= '0;
      out_is_empty <= 1'b1;
      out_dropped <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (start) begin
          key_r <= in_key;
          drop_r <= 1'b0;
          pos_r <= cnt_r;
          state_r <= S_RPT0;
          case (in_func)
            depq_pkg::FUNC_INSERT: begin
              if (cnt_r == CAP_C) drop_r <= 1'b1;
              else if (cnt_r == '0) state_r <= S_PUT;
              else state_r <= S_RD;
            end
            depq_pkg::FUNC_REM_MAX: if (cnt_r != '0) cnt_r <= cnt_r - CW'(1);
            depq_pkg::FUNC_REM_MIN: if (cnt_r != '0) begin
              cnt_r <= cnt_r - CW'(1);
              head_r <= phys(head_r, CW'(1));
            end
            default: ;
          endcase
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          if (gt) begin
            pos_r <= pos_r - CW'(1);
            state_r <= (pos_r == CW'(1)) ? S_PUT : S_RD;
          end else state_r <= S_PUT;
        end
        S_PUT: begin
          cnt_r <= cnt_r + CW'(1);
          state_r <= S_RPT0;
        end
        S_RPT0: state_r <= S_RPT1;
        S_RPT1: begin
          out_min_key <= rdat_r;
          state_r <= S_RPT2;
        end
        S_RPT2: begin
          out_valid <= 1'b1;
          out_dropped <= drop_r;
          out_is_empty <= (cnt_r == '0);
          out_max_key <= (cnt_r == '0) ? '0 : rdat_r;
          if (cnt_r == '0) out_min_key <= '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

  `ASSERT_IMPL(a_cnt_bound, clk, rst_n, cnt_r <= CAP_C)
  `ASSERT_IMPL(a_drop_full, clk, rst_n, !(out_valid && out_dropped) || cnt_r == CAP_C)
  `ASSERT_IMPL(a_done_idle, clk, rst_n, !out_valid || !busy)
  `ASSERT_NEXT(a_valid_pulse, clk, rst_n, out_valid, !out_valid)
  `ASSERT_IMPL(a_empty_zero, clk, rst_n, !(out_valid && out_is_empty) || (out_max_key == 0 && out_min_key == 0))
endmodule

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// double ended priority queue testbench
// drives insert, removal and unused-code items in bursts, predicts the largest and
// smallest stored keys with a sorted queue and checks every result
// ---------------------------------------------------------------------------
module tb;
  localparam int CAP         = 1024;
  localparam int WDOG_LIMIT  = 8 * CAP + 200;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  class depq_scoreboard;
    depq_pkg::key_t sorted_keys[$];
    depq_pkg::key_t exp_max[$];
    depq_pkg::key_t exp_min[$];
    bit       exp_empty[$];
    bit       exp_drop[$];
    int       mismatches;

    function void note_item(logic [1:0] func, depq_pkg::key_t k);
      int  pos;
      bit  drop;
      drop = 0;
      if (func == depq_pkg::FUNC_INSERT) begin
        if (sorted_keys.size() >= CAP) begin
          drop = 1;
        end else begin
          pos = sorted_keys.size();
          while (pos > 0 && sorted_keys[pos-1] > k) pos--;
          sorted_keys.insert(pos, k);
        end
      end else if (func == depq_pkg::FUNC_REM_MAX) begin
        if (sorted_keys.size() > 0) void'(sorted_keys.pop_back());
      end else if (func == depq_pkg::FUNC_REM_MIN) begin
        if (sorted_keys.size() > 0) void'(sorted_keys.pop_front());
      end
      if (sorted_keys.size() > 0) begin
        exp_max = {exp_max, sorted_keys[$]};
        exp_min = {exp_min, sorted_keys[0]};
        exp_empty = {exp_empty, 1'b0};
      end else begin
        exp_max = {exp_max, 32'sd0};
        exp_min = {exp_min, 32'sd0};
        exp_empty = {exp_empty, 1'b1};
      end
      exp_drop = {exp_drop, drop};
    endfunction

    function void check_result(depq_pkg::key_t mx, depq_pkg::key_t mn, logic emp, logic drp);
      depq_pkg::key_t e_mx, e_mn;
      bit   e_emp, e_drp;
      if (exp_max.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result max=%0d min=%0d", mx, mn);
        return;
      end
      e_mx  = exp_max.pop_front();
      e_mn  = exp_min.pop_front();
      e_emp = exp_empty.pop_front();
      e_drp = exp_drop.pop_front();
      if (mx !== e_mx || mn !== e_mn || emp !== e_emp || drp !== e_drp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp max=%0d min=%0d empty=%0b drop=%0b, got max=%0d min=%0d empty=%0b drop=%0b",
                   e_mx, e_mn, e_emp, e_drp, mx, mn, emp, drp);
      end
    endfunction

    function int pending();
      return exp_max.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_func;
  depq_pkg::key_t in_key;
  logic        out_valid;
  depq_pkg::key_t out_max_key;
  depq_pkg::key_t out_min_key;
  logic        out_is_empty;
  logic        out_dropped;

  depq_scoreboard sb;
  int             idle_cycles;
  depq_pkg::key_t hot_keys[8];

  double_ended_priority_queue #(.CAPACITY(CAP)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_key(in_key),
    .out_valid(out_valid), .out_max_key(out_max_key), .out_min_key(out_min_key),
    .out_is_empty(out_is_empty), .out_dropped(out_dropped)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // results are sampled at the edge that ends their cycle
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_max_key, out_min_key, out_is_empty, out_dropped);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // hold start until the item is taken, leave it high for a back-to-back item
  task automatic send_item(logic [1:0] func, depq_pkg::key_t k, bit keep);
    start   <= 1'b1;
    in_func <= func;
    in_key  <= k;
    do @(posedge clk); while (busy);
    sb.note_item(func, k);
    if (!keep) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic depq_pkg::key_t rand_key();
    case ($urandom_range(0, 5))
      0:       return hot_keys[$urandom_range(0, 7)];
      1:       return depq_pkg::key_t'($urandom_range(0, 40)) - 20;
      default: return depq_pkg::key_t'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n, int ins_weight, int noise_pct);
    int          left, burst;
    logic [1:0]  f;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        if ($urandom_range(0, 99) < noise_pct) f = FUNC_UNUSED;
        else if ($urandom_range(0, 99) < ins_weight) f = depq_pkg::FUNC_INSERT;
        else f = $urandom_range(0, 1) ? depq_pkg::FUNC_REM_MAX : depq_pkg::FUNC_REM_MIN;
        send_item(f, rand_key(), burst > 1 && left > 1);
        burst--;
        left--;
      end
      repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  initial begin
    sb          = new();
    hot_keys    = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1, 5, 5, -5};
    rst_n       = 1'b0;
    start       = 1'b0;
    in_func     = depq_pkg::FUNC_INSERT;
    in_key      = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty removals, extremes, duplicates, unused code
    send_item(depq_pkg::FUNC_REM_MAX, 0, 0);
    send_item(depq_pkg::FUNC_REM_MIN, 0, 0);
    send_item(FUNC_UNUSED, 32'sh1234_5678, 0);
    send_item(depq_pkg::FUNC_INSERT, 32'sh7fff_ffff, 1);
    send_item(depq_pkg::FUNC_INSERT, 32'sh8000_0000, 1);
    send_item(depq_pkg::FUNC_INSERT, 0, 1);
    send_item(depq_pkg::FUNC_INSERT, -1, 1);
    send_item(depq_pkg::FUNC_INSERT, 1, 1);
    send_item(depq_pkg::FUNC_INSERT, 7, 1);
    send_item(depq_pkg::FUNC_INSERT, 7, 1);
    send_item(FUNC_UNUSED, -1, 0);
    send_item(depq_pkg::FUNC_REM_MAX, 32'sh5555_5555, 1);
    send_item(depq_pkg::FUNC_REM_MIN, 32'shaaaa_aaaa, 1);
    send_item(depq_pkg::FUNC_REM_MAX, 0, 1);
    send_item(depq_pkg::FUNC_REM_MAX, 0, 1);
    send_item(depq_pkg::FUNC_REM_MIN, 0, 1);
    send_item(depq_pkg::FUNC_REM_MIN, 0, 1);
    send_item(depq_pkg::FUNC_REM_MIN, 0, 1);
    send_item(depq_pkg::FUNC_REM_MAX, 0, 0);

    random_phase(250, 55, 4);
    // grow the store deep so inserts walk long, then drain
    random_phase(400, 90, 2);
    random_phase(280, 30, 4);

    while (sb.pending() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
